/* src/gisg_pkg.sv */
// ----------------------------------------------------------------------------
// gisg_pkg
// Shared types and constants of the greedy independent set grouping block.
// ----------------------------------------------------------------------------
`default_nettype none
package gisg_pkg;
    localparam int unsigned DEF_MAX_CELLS  = 1024;
    localparam int unsigned DEF_NEIGHBOURS = 26;
    localparam int unsigned DEF_MAX_GROUPS = 32;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_RUN    = 2'd1,
        ST_QUERY  = 2'd2,
        ST_ERROR  = 2'd3
    } status_t;

    localparam logic [1:0] MARK_FREE    = 2'd0;
    localparam logic [1:0] MARK_PLACED  = 2'd1;
    localparam logic [1:0] MARK_BLOCKED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CLR,
        S_RSTART,
        S_SCAN,
        S_SCANW,
        S_NBRD,
        S_NBMK,
        S_NBWR,
        S_REND,
        S_UNBLK,
        S_QRD,
        S_QWAIT,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_wr;     // write neighbour table entry
        logic run_init;    // clear run counters
        logic clr_step;    // clear mark of idx, advance idx
        logic rstart;      // start of a round
        logic scan_rd;     // read mark of idx
        logic place;       // place cell idx
        logic scan_next;   // advance idx
        logic nb_rd;       // read neighbour table slot
        logic nb_mark_rd;  // read mark of fetched neighbour
        logic nb_wr;       // block neighbour if needed, advance slot
        logic rend;        // close round
        logic unblk_step;  // free blocked mark at idx
        logic fail;        // overflow
        logic succeed;     // commit run result
        logic q_rd;        // read group info and member
        logic set_result;  // latch output
    } cmd_t;

    typedef struct packed {
        logic idx_last;    // idx is last cell in use
        logic mark_free;   // read mark is free
        logic slot_last;   // slot is last
        logic all_placed;  // every cell placed
        logic group_full;  // no more groups
    } sts_t;
endpackage
`default_nettype wire

/* src/gisg_ctrl.sv */
// ----------------------------------------------------------------------------
// gisg_ctrl
// Sequencer of the grouping block: load, run rounds, query.
// ----------------------------------------------------------------------------
`default_nettype none
module gisg_ctrl
    import gisg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic       out_busy,
    output cmd_t            cmd,
    input  wire sts_t       sts
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_LOAD:  state_next = S_LOAD;
                        MODE_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next = S_CLR;
                        end
                        MODE_QUERY: state_next = S_QRD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next = S_DONE;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.idx_last)
                    state_next = S_RSTART;
            end
            S_RSTART:
            begin
                if (sts.all_placed)
                begin
                    cmd.succeed = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.group_full)
                begin
                    cmd.fail = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rstart = 1'b1;
                    cmd.scan_rd = 1'b1;
                    state_next = S_SCANW;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                if (sts.mark_free)
                begin
                    cmd.place = 1'b1;
                    state_next = S_NBRD;
                end
                else if (sts.idx_last)
                begin
                    cmd.rend = 1'b1;
                    state_next = S_UNBLK;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_NBRD:
            begin
                cmd.nb_rd = 1'b1;
                state_next = S_NBMK;
            end
            S_NBMK:
            begin
                cmd.nb_mark_rd = 1'b1;
                state_next = S_NBWR;
            end
            S_NBWR:
            begin
                cmd.nb_wr = 1'b1;
                if (!sts.slot_last)
                    state_next = S_NBRD;
                else if (sts.idx_last)
                begin
                    cmd.rend = 1'b1;
                    state_next = S_UNBLK;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_UNBLK:
            begin
                cmd.unblk_step = 1'b1;
                if (sts.idx_last)
                    state_next = S_RSTART;
            end
            S_QRD:
            begin
                cmd.q_rd = 1'b1;
                state_next = S_QWAIT;
            end
            S_QWAIT:   state_next = S_DONE;
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.set_result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* src/gisg_datapath.sv */
// ----------------------------------------------------------------------------
// gisg_datapath
// Memories, counters and result registers of the grouping block.
// ----------------------------------------------------------------------------
`default_nettype none
module gisg_datapath
    import gisg_pkg::*;
#(
    parameter int unsigned MAX_CELLS  = DEF_MAX_CELLS,
    parameter int unsigned NEIGHBOURS = DEF_NEIGHBOURS,
    parameter int unsigned MAX_GROUPS = DEF_MAX_GROUPS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_xfer,
    input  wire logic [1:0]  mode,
    input  wire logic [9:0]  cell_req,
    input  wire logic [4:0]  slot,
    input  wire logic [9:0]  neighbour,
    input  wire logic [4:0]  group,
    input  wire logic [9:0]  member,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic [1:0]       res_status,
    output logic [5:0]       res_group_count,
    output logic [10:0]      res_max_members,
    output logic [10:0]      res_member_count,
    output logic [9:0]       res_cell_out
);
    localparam int CW  = $clog2(MAX_CELLS);
    localparam int CNW = $clog2(MAX_CELLS + 1);
    localparam int SW  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int GW  = $clog2(MAX_GROUPS);
    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int TW  = $clog2(MAX_CELLS * NEIGHBOURS);
    localparam int CNTW = (CNW > 11) ? CNW : 11;

    logic [CW-1:0]  nb_mem [MAX_CELLS*NEIGHBOURS];
    logic [1:0]     mark_mem [MAX_CELLS];
    logic [CW-1:0]  ord_mem [MAX_CELLS];
    logic [CW-1:0]  gstart_mem [MAX_GROUPS];
    logic [CNW-1:0] gsize_mem [MAX_GROUPS];

    logic [CNW-1:0]  cnt_reg;             // cell_count register
    logic [CNW-1:0]  in_cnt;
    logic [1:0]      mode_reg;
    logic [CW-1:0]   creq_reg, nbr_reg;
    logic [4:0]      slot_reg, grp_reg;
    logic [9:0]      mem_reg;
    logic            load_ok_reg;

    logic [CW-1:0]   idx_reg;
    logic [SW-1:0]   sl_reg;
    logic [TW-1:0]   base_reg;
    logic [CNW-1:0]  placed_reg, pos_reg, gcnt_reg, largest_reg;
    logic [GCW-1:0]  g_reg;
    logic [1:0]      mark_rd_reg;
    logic [CW-1:0]   nb_rd_reg;
    logic [1:0]      nbm_rd_reg;
    logic            nb_ok_reg;
    logic            run_ok_reg;

    logic [GCW-1:0]  gf_reg;
    logic [CNW-1:0]  lg_reg;
    logic [CNW-1:0]  qsize_reg;
    logic [CW-1:0]   qstart_reg, qcell_reg;
    logic            qgrp_ok_reg;

    logic [CNW-1:0]  cfg_clip;
    logic [CNW:0]    qpos;

    always_comb
    begin
        if (cfg_data == 11'd0)
            cfg_clip = CNW'(1);
        else if ({21'd0, cfg_data} > 32'(MAX_CELLS))
            cfg_clip = CNW'(MAX_CELLS);
        else
            cfg_clip = CNW'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNW'(MAX_CELLS);
            gf_reg  <= '0;
            lg_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                cnt_reg <= cfg_clip;
            if (cmd.succeed)
            begin
                gf_reg <= g_reg;
                lg_reg <= largest_reg;
            end
            else if (cmd.fail)
            begin
                gf_reg <= '0;
                lg_reg <= '0;
            end
        end
    end

    assign in_cnt = cnt_reg;

    // Capture of the request fields.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= mode;
            creq_reg <= CW'(cell_req);
            nbr_reg  <= CW'(neighbour);
            slot_reg <= slot;
            grp_reg  <= group;
            mem_reg  <= member;
            load_ok_reg <= ({22'd0, cell_req} < 32'(in_cnt))
                && ({27'd0, slot} < 32'(NEIGHBOURS))
                && ({22'd0, neighbour} < 32'(in_cnt))
                && ({22'd0, cell_req} < 32'(MAX_CELLS));
        end
    end

    // Neighbour table.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok_reg)
            nb_mem[TW'(32'(creq_reg) * NEIGHBOURS + 32'(slot_reg))] <= nbr_reg;
        if (cmd.nb_rd)
            nb_rd_reg <= nb_mem[TW'(32'(base_reg) + 32'(sl_reg))];
    end

    // Mark memory: one write port, one read port.
    logic          mk_we;
    logic [CW-1:0] mk_wa;
    logic [1:0]    mk_wd;
    logic          nb_in_range;
    assign nb_in_range = 32'(nb_rd_reg) < 32'(in_cnt);

    always_comb
    begin
        mk_we = 1'b0;
        mk_wa = idx_reg;
        mk_wd = MARK_FREE;
        priority if (cmd.clr_step)
            mk_we = 1'b1;
        else if (cmd.place)
        begin
            mk_we = 1'b1;
            mk_wd = MARK_PLACED;
        end
        else if (cmd.nb_wr)
        begin
            mk_wa = nb_rd_reg;
            mk_wd = MARK_BLOCKED;
            mk_we = nb_ok_reg && (nbm_rd_reg != MARK_PLACED);
        end
        else if (cmd.unblk_step)
            mk_we = (mark_rd_reg == MARK_BLOCKED);
    end

    always_ff @(posedge clk)
    begin
        if (mk_we)
            mark_mem[mk_wa] <= mk_wd;
        if (cmd.nb_mark_rd)
            nbm_rd_reg <= mark_mem[nb_rd_reg];
        else if (cmd.scan_rd || cmd.rend || cmd.unblk_step)
            mark_rd_reg <= mark_mem[cmd.unblk_step ? CW'(idx_reg + 1'b1) :
                           (cmd.rend ? '0 : (cmd.scan_next ? idx_reg : idx_reg))];
        if (cmd.nb_mark_rd)
            nb_ok_reg <= nb_in_range;
    end

    // Run counters.
    logic idx_last;
    assign idx_last = (32'(idx_reg) + 1) >= 32'(in_cnt);

    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            idx_reg <= '0;
            placed_reg <= '0;
            pos_reg <= '0;
            g_reg <= '0;
            largest_reg <= '0;
        end
        if (cmd.clr_step || cmd.unblk_step)
            idx_reg <= idx_last ? '0 : CW'(idx_reg + 1'b1);
        if (cmd.rstart)
        begin
            gcnt_reg <= '0;
            gstart_mem[GW'(g_reg)] <= CW'(pos_reg);
        end
        if (cmd.scan_next)
            idx_reg <= CW'(idx_reg + 1'b1);
        if (cmd.place)
        begin
            ord_mem[CW'(pos_reg)] <= idx_reg;
            pos_reg <= CNW'(pos_reg + 1'b1);
            placed_reg <= CNW'(placed_reg + 1'b1);
            gcnt_reg <= CNW'(gcnt_reg + 1'b1);
            sl_reg <= '0;
            base_reg <= TW'(32'(idx_reg) * NEIGHBOURS);
        end
        if (cmd.nb_wr)
            sl_reg <= SW'(sl_reg + 1'b1);
        if (cmd.rend)
        begin
            idx_reg <= '0;
            gsize_mem[GW'(g_reg)] <= gcnt_reg;
            if (gcnt_reg > largest_reg)
                largest_reg <= gcnt_reg;
            g_reg <= GCW'(g_reg + 1'b1);
        end
        if (cmd.fail)
            run_ok_reg <= 1'b0;
        if (cmd.succeed)
            run_ok_reg <= 1'b1;
    end

    always_comb
    begin
        sts.idx_last   = idx_last;
        sts.mark_free  = (mark_rd_reg == MARK_FREE);
        sts.slot_last  = (32'(sl_reg) + 1) >= 32'(NEIGHBOURS);
        sts.all_placed = (placed_reg == in_cnt);
        sts.group_full = (32'(g_reg) >= 32'(MAX_GROUPS));
    end

    // Query path: read group info, then the member.
    logic qcell_rd_reg;
    always_ff @(posedge clk)
    begin
        qcell_rd_reg <= cmd.q_rd;
        if (cmd.q_rd)
        begin
            qgrp_ok_reg <= (32'(grp_reg) < 32'(gf_reg))
                && (32'(grp_reg) < 32'(MAX_GROUPS));
            qsize_reg  <= gsize_mem[GW'(grp_reg)];
            qstart_reg <= gstart_mem[GW'(grp_reg)];
        end
        if (qcell_rd_reg)
            qcell_reg <= ord_mem[CW'(qpos)];
    end

    assign qpos = (CNW+1)'(qstart_reg) + (CNW+1)'(mem_reg);

    // Result register.
    logic [CNTW-1:0] lg_w, qs_w;
    assign lg_w = CNTW'(lg_reg);
    assign qs_w = CNTW'(qsize_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_status       <= ST_ERROR;
            res_member_count <= '0;
            res_cell_out     <= '0;
            res_group_count  <= 6'(gf_reg);
            res_max_members  <= 11'(lg_w);
            unique case (mode_reg)
                MODE_LOAD:
                    if (load_ok_reg)
                        res_status <= ST_LOADED;
                MODE_RUN:
                    if (run_ok_reg)
                        res_status <= ST_RUN;
                MODE_QUERY:
                    if (qgrp_ok_reg)
                    begin
                        res_member_count <= 11'(qs_w);
                        if (32'(mem_reg) < 32'(qsize_reg)
                            && 32'(qpos) < 32'(MAX_CELLS))
                        begin
                            res_status   <= ST_QUERY;
                            res_cell_out <= 10'(qcell_reg);
                        end
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/greedy_independent_set_grouping.sv */
// ----------------------------------------------------------------------------
// greedy_independent_set_grouping
// Partitions cells into independent sets, one greedy round per group.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one request per
// transfer: load a neighbour entry, run the grouping, or query a member.
// Every request gives exactly one result transfer on out_valid/out_ready.
// The cell_count register is to be written through cfg_we/cfg_data only
// while idle; the block itself does not enforce this. A load writes its
// table entry, a query reads the group info and then the member, and the
// next request is taken only after the result is registered. A run first
// clears the marks, one cell per cycle, then per round scans every cell
// and checks each neighbour slot of each placed cell, then frees blocked
// marks, one cell per cycle. One request is in work at a time. A finished
// result waits in the output register while the receiver stalls; the next
// request is still taken and worked on, but its result is held until the
// register has moved, and no further request is accepted before that.
// Reset clears control state, the group count and the largest-group size
// and sets cell_count to its maximum.
// ----------------------------------------------------------------------------
`default_nettype none
module greedy_independent_set_grouping
    import gisg_pkg::*;
#(
    parameter int unsigned MAX_CELLS  = DEF_MAX_CELLS,
    parameter int unsigned NEIGHBOURS = DEF_NEIGHBOURS,
    parameter int unsigned MAX_GROUPS = DEF_MAX_GROUPS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [9:0]  cell_req,
    input  wire logic [4:0]  slot,
    input  wire logic [9:0]  neighbour,
    input  wire logic [4:0]  group,
    input  wire logic [9:0]  member,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       group_count,
    output logic [10:0]      max_members,
    output logic [10:0]      member_count,
    output logic [9:0]       cell_out
);
    cmd_t cmd;
    sts_t sts;
    logic out_valid_reg;
    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    gisg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .out_busy (out_valid_reg && !out_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gisg_datapath #(
        .MAX_CELLS  (MAX_CELLS),
        .NEIGHBOURS (NEIGHBOURS),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_xfer          (in_xfer),
        .mode             (mode),
        .cell_req         (cell_req),
        .slot             (slot),
        .neighbour        (neighbour),
        .group            (group),
        .member           (member),
        .cmd              (cmd),
        .sts              (sts),
        .res_status       (status),
        .res_group_count  (group_count),
        .res_max_members  (max_members),
        .res_member_count (member_count),
        .res_cell_out     (cell_out)
    );

    // The output register holds a result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.set_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    // A result is only produced when the output register is free or moving.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending transfer");

    // A request is only taken while the block is idle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second request taken while busy");

    // Run success and failure never coincide.
    a_run_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.succeed && cmd.fail))
        else $error("run both succeeded and failed");
endmodule
`default_nettype wire

/* bench/greedy_independent_set_grouping_tb.sv */
// ----------------------------------------------------------------------------
// greedy_independent_set_grouping_tb
// Self-checking bench for the grouping block. A directed table covers reset
// behavior, register clamping and error codes. A layered neighbour graph
// forces group overflow, and randomized phases mix loads, runs and queries
// over many cell counts. A behavioral predictor or a typed-in expectation checks every result.
// ----------------------------------------------------------------------------
`default_nettype none
module greedy_independent_set_grouping_tb;
    import gisg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CELLS_MAX = DEF_MAX_CELLS;
    localparam int unsigned NBR_SLOTS = DEF_NEIGHBOURS;
    localparam int unsigned GROUPS_MAX = DEF_MAX_GROUPS;
    localparam int unsigned RANDOM_ITEMS = 500;

    // One request as it crosses the input channel.
    typedef struct {
        mode_t       mode;
        logic [9:0]  cell_req;
        logic [4:0]  slot;
        logic [9:0]  neighbour;
        logic [4:0]  group;
        logic [9:0]  member;
    } request_t;

    // One response as it crosses the output channel.
    typedef struct {
        status_t     status;
        logic [5:0]  group_count;
        logic [10:0] max_members;
        logic [10:0] member_count;
        logic [9:0]  cell_out;
    } response_t;

    typedef enum {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_t;

    // A row of the directed table. A FILL row loads every slot of cell_req
    // with the neighbour field; a CFG row writes cell_count while idle.
    typedef struct {
        row_kind_t   kind;
        request_t    req;
        bit          typed;
        response_t   want;
        logic [10:0] cfg_val;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [9:0]  cell_req;
    logic [4:0]  slot;
    logic [9:0]  neighbour;
    logic [4:0]  group;
    logic [9:0]  member;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  group_count;
    logic [10:0] max_members;
    logic [10:0] member_count;
    logic [9:0]  cell_out;

    greedy_independent_set_grouping uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .cell_req     (cell_req),
        .slot         (slot),
        .neighbour    (neighbour),
        .group        (group),
        .member       (member),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .group_count  (group_count),
        .max_members  (max_members),
        .member_count (member_count),
        .cell_out     (cell_out)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of everything the block remembers.
    // ------------------------------------------------------------------------
    int unsigned  cells_in_use;
    logic [9:0]   nbr_table [CELLS_MAX*NBR_SLOTS];
    logic [25:0]  slot_written [CELLS_MAX];
    logic [9:0]   member_list [CELLS_MAX];
    int unsigned  grp_first [GROUPS_MAX];
    int unsigned  grp_size [GROUPS_MAX];
    int unsigned  groups_formed;
    int unsigned  largest_size;

    response_t    pending_results [$];
    int unsigned  fail_count;
    bit           no_gaps;
    bit           long_hold_req;

    // Greedy rounds: each round scans cells in order, places every free one
    // and blocks its not-yet-placed neighbours until the round closes.
    // Returns 0 when more rounds than groups would be needed.
    function automatic bit form_groups();
        logic [1:0]  marks [CELLS_MAX];
        int unsigned n;
        int unsigned placed;
        int unsigned pos;
        int unsigned g;
        int unsigned largest;
        int unsigned cnt;
        int unsigned nb;
        n = cells_in_use;
        placed = 0;
        pos = 0;
        g = 0;
        largest = 0;
        for (int unsigned i = 0; i < n; i++)
            marks[i] = MARK_FREE;
        while (placed < n)
        begin
            if (g >= GROUPS_MAX)
            begin
                groups_formed = 0;
                largest_size = 0;
                return 1'b0;
            end
            grp_first[g] = pos;
            cnt = 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (marks[i] != MARK_FREE)
                    continue;
                marks[i] = MARK_PLACED;
                member_list[pos] = i[9:0];
                pos++;
                cnt++;
                placed++;
                for (int unsigned j = 0; j < NBR_SLOTS; j++)
                begin
                    nb = nbr_table[i*NBR_SLOTS + j];
                    // Stale entries beyond the cells in use are skipped.
                    if (nb < n && marks[nb] != MARK_PLACED)
                        marks[nb] = MARK_BLOCKED;
                end
            end
            grp_size[g] = cnt;
            if (cnt > largest)
                largest = cnt;
            g++;
            for (int unsigned i = 0; i < n; i++)
                if (marks[i] == MARK_BLOCKED)
                    marks[i] = MARK_FREE;
        end
        groups_formed = g;
        largest_size = largest;
        return 1'b1;
    endfunction

    function automatic response_t predict_response(request_t rq);
        response_t   r;
        int unsigned p;
        r.status = ST_ERROR;
        r.member_count = '0;
        r.cell_out = '0;
        case (rq.mode)
            MODE_LOAD:
            begin
                if (rq.cell_req < cells_in_use && rq.slot < NBR_SLOTS
                    && rq.neighbour < cells_in_use)
                begin
                    nbr_table[rq.cell_req*NBR_SLOTS + rq.slot] = rq.neighbour;
                    slot_written[rq.cell_req][rq.slot] = 1'b1;
                    r.status = ST_LOADED;
                end
            end
            MODE_RUN:
                r.status = form_groups() ? ST_RUN : ST_ERROR;
            MODE_QUERY:
            begin
                if (rq.group < groups_formed)
                begin
                    r.member_count = grp_size[rq.group][10:0];
                    if (rq.member < grp_size[rq.group])
                    begin
                        p = grp_first[rq.group] + rq.member;
                        if (p < CELLS_MAX)
                        begin
                            r.cell_out = member_list[p];
                            r.status = ST_QUERY;
                        end
                    end
                end
            end
            default:
                r.status = ST_ERROR;
        endcase
        r.group_count = groups_formed[5:0];
        r.max_members = largest_size[10:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none at all in burst phases.
    function automatic int unsigned pick_gap(bit allow);
        int unsigned x;
        if (!allow)
            return 0;
        x = $urandom_range(0, 99);
        if (x < 55)
            return 0;
        if (x < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit and reset.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("greedy_independent_set_grouping_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: accepts results with random stalls and checks each transfer
    // against the oldest expectation. A long hold-off lets the block fill up
    // and stall its input while the sender keeps offering requests.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        response_t   exp_r;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, status %0d",
                             $time, status);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, status);
                        fail_count++;
                    end
                    if (group_count !== exp_r.group_count)
                    begin
                        $display("%0t: group_count expected %0d actual %0d",
                                 $time, exp_r.group_count, group_count);
                        fail_count++;
                    end
                    if (max_members !== exp_r.max_members)
                    begin
                        $display("%0t: max_members expected %0d actual %0d",
                                 $time, exp_r.max_members, max_members);
                        fail_count++;
                    end
                    if (member_count !== exp_r.member_count)
                    begin
                        $display("%0t: member_count expected %0d actual %0d",
                                 $time, exp_r.member_count, member_count);
                        fail_count++;
                    end
                    if (cell_out !== exp_r.cell_out)
                    begin
                        $display("%0t: cell_out expected %0d actual %0d",
                                 $time, exp_r.cell_out, cell_out);
                        fail_count++;
                    end
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(!no_gaps);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one request and holds it until the transfer. The expectation is
    // queued at the transfer, either typed in by the caller or predicted.
    task automatic send_request(request_t rq, bit typed, response_t want);
        int unsigned gap;
        response_t   r;
        gap = pick_gap(!no_gaps);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= rq.mode;
        cell_req  <= rq.cell_req;
        slot      <= rq.slot;
        neighbour <= rq.neighbour;
        group     <= rq.group;
        member    <= rq.member;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_response(rq);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic send_predicted(request_t rq);
        response_t unused;
        unused = '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0};
        send_request(rq, 1'b0, unused);
    endtask

    // Drops valid and waits until every result has moved, plus a margin for
    // the output register to settle, so the block is idle afterwards.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // The register is to be written only while idle, which the block does not
    // enforce; the predictor clamps the value the same way the block does.
    task automatic write_cell_count(logic [10:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value == 0)
            cells_in_use = 1;
        else if (value > CELLS_MAX)
            cells_in_use = CELLS_MAX;
        else
            cells_in_use = value;
    endtask

    // Loads every slot still unwritten for the cells in use, so that a run
    // never reads an entry that was never loaded.
    task automatic load_unwritten();
        request_t rq;
        for (int unsigned c = 0; c < cells_in_use; c++)
            for (int unsigned s = 0; s < NBR_SLOTS; s++)
                if (!slot_written[c][s])
                begin
                    rq = '{MODE_LOAD, c[9:0], s[4:0],
                           10'($urandom_range(0, cells_in_use - 1)), 5'd0, 10'd0};
                    send_predicted(rq);
                end
    endtask

    function automatic request_t random_request();
        request_t    rq;
        int unsigned x;
        int unsigned g;
        rq = '{MODE_LOAD, 10'($urandom), 5'($urandom), 10'($urandom),
               5'($urandom), 10'($urandom)};
        x = $urandom_range(0, 99);
        if (x < 20)
            rq.mode = MODE_RUN;
        else if (x < 55)
        begin
            // Good loads within the cells in use.
            rq.mode = MODE_LOAD;
            rq.cell_req = 10'($urandom_range(0, cells_in_use - 1));
            rq.slot = 5'($urandom_range(0, NBR_SLOTS - 1));
            rq.neighbour = 10'($urandom_range(0, cells_in_use - 1));
        end
        else if (x < 62)
            rq.mode = MODE_LOAD;
        else if (x < 90 && groups_formed > 0)
        begin
            // Valid positions mostly, with one-past-the-end probes.
            rq.mode = MODE_QUERY;
            g = $urandom_range(0, groups_formed);
            rq.group = 5'(g);
            if (g < groups_formed)
                rq.member = 10'($urandom_range(0, grp_size[g]));
        end
        else if (x < 95)
            rq.mode = MODE_QUERY;
        else
            rq.mode = MODE_NONE;
        return rq;
    endfunction

    // Directed table. Expectations are typed in where they are plain:
    // everything is an error or a bare load before the first run, and a
    // single cell forms one group of one.
    row_t directed_rows [] = '{
        '{ROW_ITEM, '{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd31, 10'd1023}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_NONE, 10'd1023, 5'd31, 10'd1023, 5'd31, 10'd1023}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd1023, 5'd25, 10'd1023, 5'd0, 10'd0}, 1'b1,
          '{ST_LOADED, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_LOADED, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd0, 5'd26, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd0, 5'd31, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_CFG, '{MODE_LOAD, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b0,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd2047},
        '{ROW_CFG, '{MODE_LOAD, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b0,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd1, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_LOAD, 10'd0, 5'd0, 10'd1, 5'd0, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_FILL, '{MODE_LOAD, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b0,
          '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_RUN, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_RUN, 6'd1, 11'd1, 11'd0, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1,
          '{ST_QUERY, 6'd1, 11'd1, 11'd1, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd1}, 1'b1,
          '{ST_ERROR, 6'd1, 11'd1, 11'd1, 10'd0}, 11'd0},
        '{ROW_ITEM, '{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd1, 10'd0}, 1'b1,
          '{ST_ERROR, 6'd1, 11'd1, 11'd0, 10'd0}, 11'd0}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        request_t    rq;
        response_t   err_r;
        int unsigned lvl_cnt [33];
        int unsigned lvl_base [33];
        int unsigned rr [33];
        int unsigned fill_cnt [64];
        logic [9:0]  nbr_plan [64][26];
        int unsigned total;
        int unsigned lister;
        int unsigned x;
        int unsigned random_sent;
        int unsigned phase_len;
        int unsigned phase_no;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        mode      = MODE_LOAD;
        cell_req  = '0;
        slot      = '0;
        neighbour = '0;
        group     = '0;
        member    = '0;
        no_gaps   = 1'b0;
        long_hold_req = 1'b0;
        fail_count = 0;
        cells_in_use = CELLS_MAX;
        groups_formed = 0;
        largest_size = 0;
        for (int unsigned c = 0; c < CELLS_MAX; c++)
            slot_written[c] = '0;
        err_r = '{ST_ERROR, 6'd0, 11'd0, 11'd0, 10'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_CFG:
                    write_cell_count(directed_rows[i].cfg_val);
                ROW_FILL:
                    for (int unsigned s = 0; s < NBR_SLOTS; s++)
                    begin
                        rq = directed_rows[i].req;
                        rq.slot = s[4:0];
                        send_predicted(rq);
                    end
                default:
                    send_request(directed_rows[i].req, directed_rows[i].typed,
                                 directed_rows[i].want);
            endcase
        end

        // Group overflow. Cells are arranged in levels 0..32, where each cell
        // of level k is listed by one cell of every lower level. A cell's
        // group is then the lowest group not taken by a cell listing it, so
        // level k lands in group k and level 32 needs a 33rd group. Low
        // levels get extra copies so no cell lists more than 26 others;
        // leftover slots point at the cell itself, which never blocks.
        lvl_cnt[32] = 1;
        total = 1;
        for (int j = 31; j >= 0; j--)
        begin
            lvl_cnt[j] = (total + NBR_SLOTS - 1) / NBR_SLOTS;
            total += lvl_cnt[j];
        end
        x = 0;
        for (int unsigned k = 0; k < 33; k++)
        begin
            lvl_base[k] = x;
            rr[k] = 0;
            x += lvl_cnt[k];
        end
        for (int unsigned c = 0; c < total; c++)
        begin
            fill_cnt[c] = 0;
            for (int unsigned s = 0; s < NBR_SLOTS; s++)
                nbr_plan[c][s] = c[9:0];
        end
        for (int unsigned k = 1; k < 33; k++)
            for (int unsigned m = 0; m < lvl_cnt[k]; m++)
                for (int unsigned j = 0; j < k; j++)
                begin
                    lister = lvl_base[j] + rr[j] % lvl_cnt[j];
                    rr[j]++;
                    nbr_plan[lister][fill_cnt[lister]] = 10'(lvl_base[k] + m);
                    fill_cnt[lister]++;
                end
        write_cell_count(11'(total));
        for (int unsigned c = 0; c < total; c++)
            for (int unsigned s = 0; s < NBR_SLOTS; s++)
                send_predicted('{MODE_LOAD, c[9:0], s[4:0], nbr_plan[c][s], 5'd0, 10'd0});
        send_request('{MODE_RUN, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1, err_r);
        send_request('{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0}, 1'b1, err_r);

        // Lowering the count leaves entries above it stale; a run skips them.
        write_cell_count(11'd20);
        send_predicted('{MODE_RUN, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0});
        send_predicted('{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd0});
        // Queries after a register change come from the stored groups.
        write_cell_count(11'd1024);
        send_predicted('{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd1, 10'd0});
        send_predicted('{MODE_LOAD, 10'd1023, 5'd0, 10'd512, 5'd0, 10'd0});
        send_predicted('{MODE_QUERY, 10'd0, 5'd0, 10'd0, 5'd0, 10'd2});

        // Random phases: a new cell count, the missing entries loaded, then a
        // mix of loads, runs and queries.
        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            x = $urandom_range(0, 99);
            if (x < 65)
                write_cell_count(11'($urandom_range(1, 12)));
            else if (x < 92)
                write_cell_count(11'($urandom_range(13, 40)));
            else
                write_cell_count(11'($urandom_range(41, 64)));
            no_gaps = ($urandom_range(0, 3) == 0);
            load_unwritten();
            if (phase_no == 1)
                long_hold_req = 1'b1;
            phase_len = $urandom_range(10, 40);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                // Once, the sender stops halfway until everything is back.
                if (phase_no == 2 && i == phase_len / 2)
                    drain();
                send_predicted(random_request());
            end
            random_sent += phase_len;
            phase_no++;
        end

        no_gaps = 1'b0;
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("greedy_independent_set_grouping_tb passed");
        else
            $display("greedy_independent_set_grouping_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
